// ===== sv/assert_macros.svh =====
// assertion macros shared by the scheduler arithmetic rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every enabled edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mlfq_pkg.sv =====
// shared widths, codes, microcode rom and control structs of the scheduler arithmetic
// no dependencies
`timescale 1ns / 1ps

package mlfq_pkg;

  // fixed point format and field widths
  localparam int FRAC_W     = 14;
  localparam int FUNC_W     = 2;
  localparam int READY_W    = 7;
  localparam int RECENT_W   = 32;
  localparam int NICE_W     = 6;
  localparam int PRI_W      = 8;
  localparam int LOAD_OUT_W = 31;

  // load never exceeds the largest ready count times 1.0
  localparam int LOAD_W = FRAC_W + READY_W;
  // divider: numerator (2*load) << frac, divisor 2*load + 1.0
  localparam int DIV_W  = 2 * FRAC_W + READY_W + 1;
  localparam int DEN_W  = FRAC_W + READY_W + 1;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  // shared multiplier: signed recent or load times a small unsigned factor
  localparam int MULA_W = RECENT_W + 1;
  localparam int MULB_W = (FRAC_W > 7) ? FRAC_W : 7;
  localparam int PROD_W = MULA_W + MULB_W + 1;

  localparam int ONE_FIX   = 1 << FRAC_W;
  localparam int HALF_FIX  = 1 << (FRAC_W - 1);
  localparam int PRIO_SH   = FRAC_W + 2;
  localparam int PRIO_ONE  = 1 << PRIO_SH;
  localparam int AGE_MUL   = 59;
  localparam int AGE_DIV   = 60;
  localparam int PCT_MUL   = 100;

  // aging by 60 as a reciprocal multiply: 59*load + ready*1.0 stays below 60 * 2^LOAD_W,
  // and a rounded-up reciprocal with 6 extra shift bits gives the exact floor
  localparam int AGE_NUM_W  = LOAD_W + 6;
  localparam int AGE_SH     = AGE_NUM_W + 6;
  localparam int AGE_RCP_W  = AGE_SH - 5;
  localparam int AGE_PROD_W = AGE_NUM_W + AGE_RCP_W;
  localparam logic [AGE_RCP_W-1:0] AGE_RCP =
    AGE_RCP_W'(((longint'(1) << AGE_SH) + longint'(AGE_DIV) - 1) / longint'(AGE_DIV));

  localparam logic [LOAD_W-1:0] LOAD_MAX =
    LOAD_W'(((1 << READY_W) - 1) << FRAC_W);
  localparam logic [PRI_W-1:0] PRI_MAX_RST = PRI_W'(63);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_THREAD = 2'd1,
    FN_TICK   = 2'd2,
    FN_REPORT = 2'd3
  } func_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_MUL_AGE,
    UOP_ADD_AGE,
    UOP_RCP_AGE,
    UOP_LOAD_WB,
    UOP_DIV_COEF,
    UOP_MUL_COEF,
    UOP_NEW_RECENT,
    UOP_PRIO,
    UOP_TICK,
    UOP_MUL_LOAD100,
    UOP_RND_LOAD,
    UOP_MUL_REC100,
    UOP_RND_REC
  } uop_t;

  // sequencer branch conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_FUNC,
    JC_IDLE,
    JC_DIV_BUSY,
    JC_DONE
  } cond_t;

  localparam int ADDR_W = 5;
  typedef logic [ADDR_W-1:0] upc_t;

  localparam upc_t A_DISPATCH  = upc_t'(0);
  localparam upc_t A_AGE       = upc_t'(1);
  localparam upc_t A_THREAD    = upc_t'(5);
  localparam upc_t A_COEF_WAIT = upc_t'(7);
  localparam upc_t A_TICK      = upc_t'(11);
  localparam upc_t A_REPORT    = upc_t'(13);
  localparam upc_t A_FIN       = upc_t'(17);

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } ucw_t;

  // sequencer to datapath
  typedef struct packed {
    uop_t uop;
    logic accept;
    logic finish;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    func_t func;
    logic  idle;
    logic  div_busy;
    logic  out_free;
  } stat_t;

  function automatic ucw_t mk_cw(uop_t u, cond_t c, upc_t t);
    ucw_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // microcode program, one control word per step
  function automatic ucw_t ucode_rom(upc_t a);
    ucw_t w;
    case (a)
      // dispatch on the operation
      upc_t'(0):  w = mk_cw(UOP_NOP,         JC_FUNC,     A_DISPATCH);
      // load update
      upc_t'(1):  w = mk_cw(UOP_MUL_AGE,     JC_NEXT,     A_DISPATCH);
      upc_t'(2):  w = mk_cw(UOP_ADD_AGE,     JC_NEXT,     A_DISPATCH);
      upc_t'(3):  w = mk_cw(UOP_RCP_AGE,     JC_NEXT,     A_DISPATCH);
      upc_t'(4):  w = mk_cw(UOP_LOAD_WB,     JC_GOTO,     A_FIN);
      // thread recompute
      upc_t'(5):  w = mk_cw(UOP_NOP,         JC_IDLE,     A_FIN);
      upc_t'(6):  w = mk_cw(UOP_DIV_COEF,    JC_NEXT,     A_DISPATCH);
      upc_t'(7):  w = mk_cw(UOP_NOP,         JC_DIV_BUSY, A_COEF_WAIT);
      upc_t'(8):  w = mk_cw(UOP_MUL_COEF,    JC_NEXT,     A_DISPATCH);
      upc_t'(9):  w = mk_cw(UOP_NEW_RECENT,  JC_NEXT,     A_DISPATCH);
      upc_t'(10): w = mk_cw(UOP_PRIO,        JC_GOTO,     A_FIN);
      // tick charge
      upc_t'(11): w = mk_cw(UOP_NOP,         JC_IDLE,     A_FIN);
      upc_t'(12): w = mk_cw(UOP_TICK,        JC_GOTO,     A_FIN);
      // report
      upc_t'(13): w = mk_cw(UOP_MUL_LOAD100, JC_NEXT,     A_DISPATCH);
      upc_t'(14): w = mk_cw(UOP_RND_LOAD,    JC_NEXT,     A_DISPATCH);
      upc_t'(15): w = mk_cw(UOP_MUL_REC100,  JC_NEXT,     A_DISPATCH);
      upc_t'(16): w = mk_cw(UOP_RND_REC,     JC_NEXT,     A_DISPATCH);
      // hand the result to the output register
      upc_t'(17): w = mk_cw(UOP_NOP,         JC_DONE,     A_FIN);
      default:    w = mk_cw(UOP_NOP,         JC_GOTO,     A_FIN);
    endcase
    return w;
  endfunction

  // first step of each operation
  function automatic upc_t entry_of(func_t f);
    upc_t a;
    case (f)
      FN_LOAD:   a = A_AGE;
      FN_THREAD: a = A_THREAD;
      FN_TICK:   a = A_TICK;
      FN_REPORT: a = A_REPORT;
      default:   a = A_FIN;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/mlfq_if.sv =====
// valid/ready channel interfaces: input item, result item, configuration write
// depends on mlfq_pkg for field widths
`timescale 1ns / 1ps

interface mlfq_in_if;
  import mlfq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [READY_W-1:0]         ready_count;
  logic signed [RECENT_W-1:0] recent_in;
  logic signed [NICE_W-1:0]   nice_in;
  logic                       is_idle;

  modport source (output valid, func, ready_count, recent_in, nice_in, is_idle,
                  input ready);
  modport sink (input valid, func, ready_count, recent_in, nice_in, is_idle,
                output ready);
endinterface

interface mlfq_out_if;
  import mlfq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RECENT_W-1:0] recent_out;
  logic signed [RECENT_W-1:0] priority_out;
  logic [LOAD_OUT_W-1:0]      load_out;
  logic [LOAD_OUT_W-1:0]      load_times_100;
  logic signed [RECENT_W-1:0] recent_times_100;

  modport source (output valid, recent_out, priority_out, load_out, load_times_100,
                  recent_times_100, input ready);
  modport sink (input valid, recent_out, priority_out, load_out, load_times_100,
                recent_times_100, output ready);
endinterface

interface mlfq_cfg_if;
  import mlfq_pkg::*;
  logic             valid;
  logic             ready;
  logic [PRI_W-1:0] pri_max;

  modport source (output valid, pri_max, input ready);
  modport sink (input valid, pri_max, output ready);
endinterface

// ===== sv/mlfq_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on mlfq_pkg for widths and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mlfq_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mlfq_pkg::DIV_W-1:0] num,
  input  logic [mlfq_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [mlfq_pkg::DIV_W-1:0] quot
);
  import mlfq_pkg::*;

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W:0]     shifted;
  logic               ge;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_W);
    end else if (busy_r) begin
      busy_r <= cnt_r != CNT_W'(1);
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

  `ASSERT_IMPL(a_start_idle, start, !busy_r, "divider restarted while busy")
  `ASSERT_IMPL(a_rem_range, busy_r, rem_r < den_r, "partial remainder not below divisor")

endmodule

// ===== sv/mlfq_seq.sv =====
// microcode sequencer: step counter, control rom lookup and branch logic
// depends on mlfq_pkg and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mlfq_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlfq_pkg::stat_t stat,
  output mlfq_pkg::ctrl_t ctrl
);
  import mlfq_pkg::*;

  logic busy_r, busy_nxt;
  upc_t pc_r, pc_nxt;
  ucw_t cw;
  logic accept;
  logic done;
  logic blocked;

  assign cw       = ucode_rom(pc_r);
  assign in_ready = !busy_r;
  assign accept   = in_valid && !busy_r;
  assign done     = busy_r && (cw.cond == JC_DONE) && stat.out_free;
  assign blocked  = busy_r && (cw.cond == JC_DONE) && !stat.out_free;

  // next step
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (accept) begin
      pc_nxt   = A_DISPATCH;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (cw.cond)
        JC_NEXT:     pc_nxt = pc_r + upc_t'(1);
        JC_GOTO:     pc_nxt = cw.target;
        JC_FUNC:     pc_nxt = entry_of(stat.func);
        JC_IDLE:     pc_nxt = stat.idle ? cw.target : pc_r + upc_t'(1);
        JC_DIV_BUSY: pc_nxt = stat.div_busy ? cw.target : pc_r + upc_t'(1);
        JC_DONE: begin
          if (stat.out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default:     pc_nxt = A_FIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= A_DISPATCH;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // control word to the datapath
  always_comb begin
    ctrl.uop    = busy_r ? cw.uop : UOP_NOP;
    ctrl.accept = accept;
    ctrl.finish = done;
  end

  `ASSERT_NEXT(a_fin_hold, blocked, busy_r && pc_r == $past(pc_r), "blocked final step left")

endmodule

// ===== sv/mlfq_dp.sv =====
// datapath: operand registers, shared multiplier, divider, result and output registers
// depends on mlfq_pkg, mlfq_div and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mlfq_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mlfq_pkg::ctrl_t                    ctrl,
  input  logic [mlfq_pkg::PRI_W-1:0]         pri_max,
  input  logic [mlfq_pkg::FUNC_W-1:0]        in_func,
  input  logic [mlfq_pkg::READY_W-1:0]       in_ready_count,
  input  logic signed [mlfq_pkg::RECENT_W-1:0] in_recent,
  input  logic signed [mlfq_pkg::NICE_W-1:0] in_nice,
  input  logic                               in_idle,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [mlfq_pkg::RECENT_W-1:0] out_recent,
  output logic signed [mlfq_pkg::RECENT_W-1:0] out_prio,
  output logic [mlfq_pkg::LOAD_OUT_W-1:0]    out_load,
  output logic [mlfq_pkg::LOAD_OUT_W-1:0]    out_load100,
  output logic signed [mlfq_pkg::RECENT_W-1:0] out_recent100,
  output mlfq_pkg::stat_t                    stat
);
  import mlfq_pkg::*;

  // captured transaction
  func_t                      func_r;
  logic [READY_W-1:0]         ready_r;
  logic signed [RECENT_W-1:0] recent_r;
  logic signed [NICE_W-1:0]   nice_r;
  logic                       idle_r;

  // state and working registers
  logic [LOAD_W-1:0]          load_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [AGE_PROD_W-1:0]      age_prod_r;
  logic signed [RECENT_W-1:0] res_recent_r;
  logic signed [RECENT_W-1:0] prio_r;
  logic [LOAD_OUT_W-1:0]      l100_r;
  logic signed [RECENT_W-1:0] r100_r;

  // output register
  logic                       out_valid_r;
  logic signed [RECENT_W-1:0] o_recent_r;
  logic signed [RECENT_W-1:0] o_prio_r;
  logic [LOAD_OUT_W-1:0]      o_load_r;
  logic [LOAD_OUT_W-1:0]      o_load100_r;
  logic signed [RECENT_W-1:0] o_recent100_r;

  // combinational helpers
  logic signed [MULA_W-1:0]   mul_a;
  logic [MULB_W-1:0]          mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       div_start;
  logic [DIV_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic                       div_busy;
  logic [DIV_W-1:0]           div_quot;
  logic signed [PROD_W-1:0]   prod_adj, prod_q;
  logic signed [RECENT_W-1:0] new_recent;
  logic signed [RECENT_W:0]   rq_adj, rq;
  logic signed [RECENT_W-1:0] new_prio;
  logic signed [PROD_W-1:0]   rnd_pos, rnd_neg;
  logic                       out_free;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.uop)
      UOP_MUL_AGE: begin
        mul_a = MULA_W'(load_r);
        mul_b = MULB_W'(AGE_MUL);
      end
      UOP_MUL_COEF: begin
        mul_a = MULA_W'(recent_r);
        mul_b = div_quot[MULB_W-1:0];
      end
      UOP_MUL_LOAD100: begin
        mul_a = MULA_W'(load_r);
        mul_b = MULB_W'(PCT_MUL);
      end
      default: begin
        mul_a = MULA_W'(recent_r);
        mul_b = MULB_W'(PCT_MUL);
      end
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  // divider operands: the decay coefficient 2*load / (2*load + 1.0)
  always_comb begin
    div_start = (ctrl.uop == UOP_DIV_COEF);
    div_num   = DIV_W'(load_r) << (FRAC_W + 1);
    div_den   = (DEN_W'(load_r) << 1) + DEN_W'(ONE_FIX);
  end

  mlfq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // coef * recent / 1.0 toward zero, plus nice
  always_comb begin
    prod_adj   = prod_r + (prod_r[PROD_W-1] ? PROD_W'(ONE_FIX - 1) : PROD_W'(0));
    prod_q     = prod_adj >>> FRAC_W;
    new_recent = prod_q[RECENT_W-1:0] + (RECENT_W'(nice_r) << FRAC_W);
  end

  // priority from the new recent value, quarter taken toward zero
  always_comb begin
    rq_adj   = {res_recent_r[RECENT_W-1], res_recent_r}
             + (res_recent_r[RECENT_W-1] ? (RECENT_W + 1)'(PRIO_ONE - 1)
                                         : (RECENT_W + 1)'(0));
    rq       = rq_adj >>> PRIO_SH;
    new_prio = RECENT_W'(pri_max) - rq[RECENT_W-1:0] - (RECENT_W'(nice_r) <<< 1);
  end

  // rounding of the scaled products, half away from zero
  always_comb begin
    rnd_pos = (prod_r + PROD_W'(HALF_FIX)) >>> FRAC_W;
    rnd_neg = (PROD_W'(HALF_FIX) - prod_r) >>> FRAC_W;
  end

  // load average state, aged sum times the reciprocal of 60
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else if (ctrl.uop == UOP_LOAD_WB) begin
      load_r <= age_prod_r[AGE_SH +: LOAD_W];
    end
  end

  // capture and micro-operations
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      func_r       <= func_t'(in_func);
      ready_r      <= in_ready_count;
      recent_r     <= in_recent;
      nice_r       <= in_nice;
      idle_r       <= in_idle;
      res_recent_r <= in_recent;
      prio_r       <= '0;
      l100_r       <= '0;
      r100_r       <= '0;
    end else begin
      case (ctrl.uop)
        UOP_MUL_AGE, UOP_MUL_COEF, UOP_MUL_LOAD100, UOP_MUL_REC100: prod_r <= mul_p;
        UOP_ADD_AGE:    prod_r <= prod_r + (PROD_W'(ready_r) << FRAC_W);
        UOP_RCP_AGE:    age_prod_r <= prod_r[AGE_NUM_W-1:0] * AGE_RCP;
        UOP_NEW_RECENT: res_recent_r <= new_recent;
        UOP_PRIO:       prio_r <= new_prio;
        UOP_TICK:       res_recent_r <= recent_r + RECENT_W'(ONE_FIX);
        UOP_RND_LOAD:   l100_r <= rnd_pos[LOAD_OUT_W-1:0];
        UOP_RND_REC: begin
          r100_r <= prod_r[PROD_W-1] ? -rnd_neg[RECENT_W-1:0] : rnd_pos[RECENT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // output register, loaded when the program finishes
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      o_recent_r    <= res_recent_r;
      o_prio_r      <= prio_r;
      o_load_r      <= LOAD_OUT_W'(load_r);
      o_load100_r   <= l100_r;
      o_recent100_r <= r100_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_recent    = o_recent_r;
  assign out_prio      = o_prio_r;
  assign out_load      = o_load_r;
  assign out_load100   = o_load100_r;
  assign out_recent100 = o_recent100_r;

  always_comb begin
    stat.func     = func_r;
    stat.idle     = idle_r;
    stat.div_busy = div_busy;
    stat.out_free = out_free;
  end

  `ASSERT_ALWAYS(a_load_bound, load_r <= LOAD_MAX, "load average above its ceiling")
  `ASSERT_IMPL(a_fin_slot, ctrl.finish, out_free, "result overwrote a pending transaction")

endmodule

// ===== sv/mlfq_scheduler_arithmetic_core.sv =====
// Scheduler arithmetic unit: load average, recent cpu and priority in 17.14 fixed point.
// Input channel in_ch carries one operation per transaction (func, ready_count,
// recent_in, nice_in, is_idle); result channel out_ch returns exactly one result per
// transaction. cfg_ch writes pri_max (always ready); write it only while the unit is idle.
// Each operation runs as a short microcode program over one datapath; one item at a time.
// Thread recompute uses the restoring divider for the decay coefficient, at one quotient
// bit per cycle; the load update divides by 60 with a reciprocal multiply. An idle thread
// recompute or tick skips its arithmetic and goes straight to the final step.
// in_ready returns in the same cycle that the result appears in the output register.
// A new item is taken as soon as the previous result sits in the output register,
// even if the receiver has not yet taken it.
// If the receiver stalls, the output register holds its result and the next item
// waits on its final step until that register frees up; nothing is dropped.
// Reset (rst_n low at a clock edge) clears the load average to 0, sets pri_max to 63
// and empties the output register; no clearing pass is needed.
// Depends on mlfq_pkg, mlfq_if, mlfq_seq and mlfq_dp.
`timescale 1ns / 1ps

module mlfq_scheduler_arithmetic_core (
  input  logic              clk,
  input  logic              rst_n,
  mlfq_in_if.sink           in_ch,
  mlfq_out_if.source        out_ch,
  mlfq_cfg_if.sink          cfg_ch
);
  import mlfq_pkg::*;

  logic [PRI_W-1:0] pri_max_r;
  ctrl_t            ctrl;
  stat_t            stat;
  logic             seq_in_ready;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_max_r <= PRI_MAX_RST;
    end else if (cfg_ch.valid) begin
      pri_max_r <= cfg_ch.pri_max;
    end
  end

  // sequencer
  mlfq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (seq_in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = seq_in_ready;

  // datapath
  mlfq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .pri_max        (pri_max_r),
    .in_func        (in_ch.func),
    .in_ready_count (in_ch.ready_count),
    .in_recent      (in_ch.recent_in),
    .in_nice        (in_ch.nice_in),
    .in_idle        (in_ch.is_idle),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_recent     (out_ch.recent_out),
    .out_prio       (out_ch.priority_out),
    .out_load       (out_ch.load_out),
    .out_load100    (out_ch.load_times_100),
    .out_recent100  (out_ch.recent_times_100),
    .stat           (stat)
  );

endmodule
